[design/quadratic_probe_hash_table_macros.svh]
// assertion macros shared by the hash table modules
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// implication checked on every clock edge outside reset
`define QPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequence is checked in the following cycle
`define QPH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/qph_pkg.sv]
// shared types and constants of the hash table
`default_nettype none
package qph_pkg;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SlotW  = 9;
  localparam int unsigned SizeW  = 10;
  localparam int unsigned HashW  = 32;
  localparam logic [SizeW-1:0] SizeReset = 10'd503;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActLookup = 2'd1;
  localparam logic [1:0] ActDelete = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ValW-1:0]  found_value;
    logic [SlotW-1:0] slot;
  } out_item_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MOD,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ADDR,
    BS_READ,
    BS_CHECK,
    BS_DONE,
    BS_CLEAR
  } back_state_t;
endpackage
`default_nettype wire

[design/qph_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module qph_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[design/qph_front.sv]
// front end: takes items, hashes the key and reduces it to a home slot
`default_nettype none
module qph_front #(
  parameter int unsigned SLOTS     = 512,
  parameter int unsigned KEY_BYTES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire qph_pkg::in_item_t          item,
  input  wire logic [$clog2(SLOTS):0]     size,
  output logic                            busy,
  output logic                            q_push,
  output qph_pkg::in_item_t               q_item,
  output logic [$clog2(SLOTS)-1:0]        q_home,
  input  wire logic                       q_full
);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned HW = qph_pkg::HashW;

  qph_pkg::front_state_t state_r, state_nxt;
  qph_pkg::in_item_t item_r;
  logic [HW-1:0] rem_r, rem_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [qph_pkg::KeyW-1:0] kmask;
  logic [HW-1:0] hash;

  always_comb begin
    logic [qph_pkg::KeyW-1:0] km;
    logic [HW-1:0] h;
    km = '0;
    h = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      km[8*i +: 8] = 8'hff;
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      h = h + (HW'(item.key[8*i +: 8]) << (4 * (i % 8)));
    end
    kmask = km;
    hash = h;
  end

  // restoring reduction: subtract size<<cnt when it fits, one bit a cycle
  always_comb begin
    logic [HW+AW:0] sh;
    state_nxt = state_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    q_push = 1'b0;
    sh = (HW+AW+1)'(size) << cnt_r;
    unique case (state_r)
      qph_pkg::FS_IDLE: begin
        if (start) begin
          rem_nxt = hash;
          cnt_nxt = 6'(HW - 1);
          state_nxt = qph_pkg::FS_MOD;
        end
      end
      qph_pkg::FS_MOD: begin
        if (sh <= (HW+AW+1)'(rem_r)) begin
          rem_nxt = rem_r - HW'(sh);
        end
        if (cnt_r == '0) begin
          state_nxt = qph_pkg::FS_PUSH;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      qph_pkg::FS_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          state_nxt = qph_pkg::FS_IDLE;
        end
      end
      default: state_nxt = qph_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qph_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start && state_r == qph_pkg::FS_IDLE) begin
      item_r.action <= item.action;
      item_r.key <= item.key & kmask;
      item_r.value <= item.value;
    end
  end

  assign busy = (state_r != qph_pkg::FS_IDLE);
  assign q_item = item_r;
  assign q_home = rem_r[AW-1:0];
endmodule
`default_nettype wire

[design/qph_back.sv]
// back end: walks the probe path through the slot memories
`default_nettype none
`include "quadratic_probe_hash_table_macros.svh"
module qph_back #(
  parameter int unsigned SLOTS      = 512,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire qph_pkg::in_item_t      q_item,
  input  wire logic [$clog2(SLOTS)-1:0] q_home,
  output logic                        q_pop,
  input  wire logic [$clog2(SLOTS):0] size,
  output logic                        done,
  output qph_pkg::out_item_t          result,
  output logic                        idle
);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned KW = qph_pkg::KeyW;

  qph_pkg::back_state_t state_r, state_nxt;
  qph_pkg::in_item_t item_r;
  logic [SW-1:0] k_r, k_nxt;
  logic [AW:0] pos_r, pos_nxt;
  logic [AW:0] step_r, step_nxt;
  logic [AW-1:0] addr;
  logic key_we, val_we;
  logic [KW-1:0] rkey;
  logic [VALUE_BITS-1:0] rval, wval;
  qph_pkg::out_item_t res_r, res_nxt;
  logic done_r, done_nxt;
  logic set_used, clr_used, clearing;
  logic used_we, used_wd, rused;
  logic [SW-1:0] half;
  logic [AW:0] pos_add, pos_wrap, step_add, step_wrap;

  assign half = size >> 1;
  assign addr = pos_r[AW-1:0];

  // incremental quadratic walk: p(k+1) = p(k) + 2k+1, step kept below size
  always_comb begin
    pos_add = pos_r + step_r;
    pos_wrap = (pos_add >= (AW+1)'(size)) ? pos_add - (AW+1)'(size) : pos_add;
    step_add = step_r + (AW+1)'(2);
    step_wrap = (step_add >= (AW+1)'(size)) ? step_add - (AW+1)'(size) : step_add;
  end

  always_comb begin
    logic fit;
    state_nxt = state_r;
    k_nxt = k_r;
    pos_nxt = pos_r;
    step_nxt = step_r;
    res_nxt = res_r;
    done_nxt = 1'b0;
    q_pop = 1'b0;
    key_we = 1'b0;
    val_we = 1'b0;
    set_used = 1'b0;
    clr_used = 1'b0;
    clearing = 1'b0;
    fit = 1'b0;
    unique case (state_r)
      // after reset every used flag is written to zero, one slot a cycle
      qph_pkg::BS_CLEAR: begin
        clearing = 1'b1;
        pos_nxt = pos_r + (AW+1)'(1);
        if (pos_r == (AW+1)'(SLOTS - 1)) begin
          state_nxt = qph_pkg::BS_IDLE;
        end
      end
      qph_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          k_nxt = '0;
          pos_nxt = (AW+1)'(q_home);
          step_nxt = (AW+1)'(1) >= (AW+1)'(size) ? '0 : (AW+1)'(1);
          state_nxt = qph_pkg::BS_ADDR;
        end
      end
      qph_pkg::BS_ADDR: begin
        state_nxt = qph_pkg::BS_READ;
      end
      qph_pkg::BS_READ: begin
        state_nxt = qph_pkg::BS_CHECK;
      end
      qph_pkg::BS_CHECK: begin
        res_nxt = '{status: qph_pkg::StMissing, found_value: '0, slot: '0};
        if (item_r.action == qph_pkg::ActInsert) begin
          fit = !rused;
          if (fit) begin
            key_we = 1'b1;
            val_we = 1'b1;
            set_used = 1'b1;
            res_nxt.status = qph_pkg::StOk;
            res_nxt.slot = qph_pkg::SlotW'(addr);
          end
        end else if (item_r.action == qph_pkg::ActLookup ||
                     item_r.action == qph_pkg::ActDelete) begin
          fit = rused && rkey == item_r.key;
          if (fit) begin
            clr_used = (item_r.action == qph_pkg::ActDelete);
            res_nxt.status = qph_pkg::StOk;
            res_nxt.found_value = qph_pkg::ValW'(rval);
            res_nxt.slot = qph_pkg::SlotW'(addr);
          end
        end else begin
          fit = 1'b1;
        end
        if (!fit && item_r.action == qph_pkg::ActInsert) begin
          res_nxt.status = qph_pkg::StFull;
        end
        if (fit || k_r >= half) begin
          done_nxt = 1'b1;
          state_nxt = qph_pkg::BS_IDLE;
        end else begin
          k_nxt = k_r + SW'(1);
          pos_nxt = pos_wrap;
          step_nxt = step_wrap;
          state_nxt = qph_pkg::BS_ADDR;
        end
      end
      default: state_nxt = qph_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qph_pkg::BS_CLEAR;
      pos_r <= '0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      done_r <= done_nxt;
    end
    k_r <= k_nxt;
    step_r <= step_nxt;
    res_r <= res_nxt;
    if (q_pop) begin
      item_r <= q_item;
    end
  end

  assign wval = VALUE_BITS'(item_r.value);
  assign used_we = set_used || clr_used || clearing;
  assign used_wd = set_used;

  qph_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key_ram (
    .clk(clk), .we(key_we), .addr(addr), .wdata(item_r.key), .rdata(rkey)
  );

  qph_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
    .clk(clk), .we(val_we), .addr(addr), .wdata(wval), .rdata(rval)
  );

  qph_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_ram (
    .clk(clk), .we(used_we), .addr(addr), .wdata(used_wd), .rdata(rused)
  );

  assign done = done_r;
  assign result = res_r;
  assign idle = (state_r == qph_pkg::BS_IDLE) && !q_valid;

  `QPH_ASSERT_IMP(a_pos_in_range, clk, rst_n, state_r == qph_pkg::BS_CHECK,
    pos_r < (AW+1)'(size), "probe position outside table")
  `QPH_ASSERT_IMP(a_no_set_and_clear, clk, rst_n, set_used, !clr_used,
    "slot set and cleared together")
  `QPH_ASSERT_NXT(a_done_after_check, clk, rst_n, done_nxt,
    done && $past(state_r) == qph_pkg::BS_CHECK, "result without probe check")
endmodule
`default_nettype wire

[design/quadratic_probe_hash_table.sv]
// Open-addressing key-value table with quadratic probing.
// Items enter on in_* when start is high and busy is low: action 0 insert,
// 1 lookup, 2 delete. The front end hashes the key (32-bit sum of bytes
// shifted by 4*i) and reduces it modulo the table size with a one bit per
// cycle restoring reduction, then hands the item off. A one-entry queue
// passes the item to the back end, which walks home + k*k using the slot
// memories; each probed slot takes an address step, a registered read and
// a compare, up to size/2+1 probes.
// The front can hash the next item while the back end is probing. busy
// stays high from an accept until the item is pushed into the queue,
// longer while the queue is still occupied.
// Each result appears on out_* for one cycle marked by out_valid; the
// receiver cannot stall it. Reset sets table_size to 503 and starts a
// clearing pass over the slot-used memory; the front may take two items
// meanwhile, one waiting in the queue and one in the front end, until the
// pass ends. table_size is written through the APB port at address 0;
// the user must write it only while idle, which the block itself does not
// enforce. It is saturated into 2..SLOTS.
`default_nettype none
`include "quadratic_probe_hash_table_macros.svh"
module quadratic_probe_hash_table #(
  parameter int unsigned SLOTS      = 512,
  parameter int unsigned KEY_BYTES  = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire qph_pkg::in_item_t     in_item,
  output logic                       out_valid,
  output qph_pkg::out_item_t         out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [1:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  localparam int unsigned AW = $clog2(SLOTS);

  logic [qph_pkg::SizeW-1:0] size_r;
  logic [AW:0] size_eff;
  logic fr_busy, q_push, q_pop, q_valid_r, be_idle;
  qph_pkg::in_item_t fr_item, q_item_r;
  logic [AW-1:0] fr_home, q_home_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr == 2'd0;
  assign prdata = (paddr == 2'd0) ? 32'(size_r) : '0;

  always_comb begin
    if (size_r < qph_pkg::SizeW'(2)) begin
      size_eff = (AW+1)'(2);
    end else if (32'(size_r) > SLOTS) begin
      size_eff = (AW+1)'(SLOTS);
    end else begin
      size_eff = (AW+1)'(size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= qph_pkg::SizeReset;
      q_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        size_r <= pwdata[qph_pkg::SizeW-1:0];
      end
      if (q_push) begin
        q_valid_r <= 1'b1;
      end else if (q_pop) begin
        q_valid_r <= 1'b0;
      end
    end
    if (q_push) begin
      q_item_r <= fr_item;
      q_home_r <= fr_home;
    end
  end

  qph_front #(.SLOTS(SLOTS), .KEY_BYTES(KEY_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .item(in_item), .size(size_eff),
    .busy(fr_busy), .q_push(q_push), .q_item(fr_item), .q_home(fr_home),
    .q_full(q_valid_r)
  );

  qph_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid_r), .q_item(q_item_r),
    .q_home(q_home_r), .q_pop(q_pop), .size(size_eff), .done(out_valid),
    .result(out_item), .idle(be_idle)
  );

  assign busy = fr_busy;

  `QPH_ASSERT_IMP(a_no_push_when_full, clk, rst_n, q_push, !q_valid_r,
    "queue overrun")
  `QPH_ASSERT_NXT(a_pop_clears, clk, rst_n, q_pop && !q_push, !q_valid_r,
    "queue entry kept after pop")
  `QPH_ASSERT_IMP(a_idle_consistent, clk, rst_n, be_idle, !q_valid_r,
    "back end idle with queued item")
endmodule
`default_nettype wire

[bench/hash_table_checker.sv]
// checker: predicts table results from accepted items and compares them
module hash_table_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  qph_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  qph_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 512;

  logic [qph_pkg::SizeW-1:0] size_reg;
  logic                      used_mem [Slots];
  logic [qph_pkg::KeyW-1:0]  key_mem  [Slots];
  logic [qph_pkg::ValW-1:0]  val_mem  [Slots];
  qph_pkg::out_item_t        expected_results [$];

  function automatic int unsigned home_slot(logic [qph_pkg::KeyW-1:0] key,
                                            int unsigned size);
    logic [31:0] h;
    h = 0;
    for (int i = 0; i < 8; i++) h += 32'(key[8*i +: 8]) << (4 * i);
    return h % size;
  endfunction

  // updates the table copy and returns the result of one item
  function automatic qph_pkg::out_item_t apply_item(qph_pkg::in_item_t it);
    qph_pkg::out_item_t r;
    int unsigned size, home, p;
    size = size_reg < 2 ? 2 : (size_reg > Slots ? Slots : size_reg);
    home = home_slot(it.key, size);
    r = '{status: qph_pkg::StMissing, found_value: '0, slot: '0};
    if (it.action == qph_pkg::ActInsert) begin
      r.status = qph_pkg::StFull;
      for (int k = 0; k <= size / 2; k++) begin
        p = (home + k * k) % size;
        if (!used_mem[p]) begin
          used_mem[p] = 1'b1;
          key_mem[p] = it.key;
          val_mem[p] = it.value;
          r.status = qph_pkg::StOk;
          r.slot = p[qph_pkg::SlotW-1:0];
          break;
        end
      end
    end else if (it.action == qph_pkg::ActLookup || it.action == qph_pkg::ActDelete) begin
      for (int k = 0; k <= size / 2; k++) begin
        p = (home + k * k) % size;
        if (used_mem[p] && key_mem[p] == it.key) begin
          r.status = qph_pkg::StOk;
          r.found_value = val_mem[p];
          r.slot = p[qph_pkg::SlotW-1:0];
          if (it.action == qph_pkg::ActDelete) used_mem[p] = 1'b0;
          break;
        end
      end
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    qph_pkg::out_item_t exp_r;
    if (!rst_n) begin
      size_reg <= qph_pkg::SizeReset;
      for (int i = 0; i < Slots; i++) used_mem[i] = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_item) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", exp_r, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_item(in_item));
      if (psel && penable && pwrite && pready && paddr == 2'd0)
        size_reg <= pwdata[qph_pkg::SizeW-1:0];
    end
  end

  initial fail_count = 0;
endmodule

[bench/testbench.sv]
// top of the hash table bench: stimulus, configuration and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n, start, busy, out_valid;
  qph_pkg::in_item_t in_item;
  qph_pkg::out_item_t out_item;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending;
  int unsigned cycles;

  logic [qph_pkg::KeyW-1:0] live_keys [$];
  int unsigned cur_size;

  quadratic_probe_hash_table dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  hash_table_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6_000_000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // start stays high after an accept; busy holds off a second accept until
  // the caller either sends again or drops start
  task automatic send_item(logic [1:0] act, logic [qph_pkg::KeyW-1:0] key,
                           logic [qph_pkg::ValW-1:0] val);
    start <= 1'b1;
    in_item <= '{action: act, key: key, value: val};
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_empty();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (900) @(posedge clk);
  endtask

  task automatic write_size(logic [31:0] sz);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= sz;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cur_size = sz[9:0];
  endtask

  // keys mostly small so that collisions and chains appear often
  function automatic logic [qph_pkg::KeyW-1:0] rand_key();
    logic [qph_pkg::KeyW-1:0] k;
    case ($urandom_range(3))
      0: k = $urandom_range(40);
      1: k = {$urandom, $urandom};
      default: k = $urandom_range(0, 4 * cur_size + 8);
    endcase
    return k;
  endfunction

  task automatic random_phase(int n);
    logic [qph_pkg::KeyW-1:0] k;
    int a;
    for (int i = 0; i < n; i++) begin
      a = $urandom_range(9);
      if (a < 4 || live_keys.size() == 0) begin
        k = rand_key();
        send_item(qph_pkg::ActInsert, k, $urandom);
        live_keys.push_back(k);
        if (live_keys.size() > 200) void'(live_keys.pop_front());
      end else begin
        k = ($urandom_range(3) == 0) ? rand_key()
            : live_keys[$urandom_range(live_keys.size() - 1)];
        send_item(a == 9 ? 2'd3 : (a < 7 ? qph_pkg::ActLookup : qph_pkg::ActDelete),
                  k, $urandom);
      end
      if ($urandom_range(7) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      if (i == n / 2) wait_empty();
    end
  endtask

  initial begin
    cycles = 0;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cur_size = 503;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all actions, full table, code 3
    send_item(qph_pkg::ActInsert, '0, '0);
    send_item(qph_pkg::ActInsert, '1, '1);
    send_item(qph_pkg::ActInsert, 64'h0102030405060708, 32'hdeadbeef);
    send_item(qph_pkg::ActLookup, '1, '0);
    send_item(qph_pkg::ActLookup, 64'h0102030405060708, '0);
    send_item(qph_pkg::ActLookup, 64'h5555, '0);
    send_item(qph_pkg::ActDelete, '0, '0);
    send_item(qph_pkg::ActDelete, '0, '0);
    send_item(2'd3, '1, '1);
    send_item(qph_pkg::ActInsert, '1, 32'h5a5a5a5a);
    send_item(qph_pkg::ActDelete, '1, '0);
    send_item(qph_pkg::ActLookup, '1, '0);
    write_size(2);
    for (int i = 0; i < 4; i++) send_item(qph_pkg::ActInsert, 64'(i), 32'(i));
    send_item(qph_pkg::ActLookup, 64'd3, '0);
    write_size(0);
    send_item(qph_pkg::ActInsert, 64'd9, '1);
    send_item(qph_pkg::ActLookup, 64'd9, '0);
    write_size(1023);
    send_item(qph_pkg::ActLookup, 64'd9, '0);
    send_item(qph_pkg::ActInsert, 64'hffff_0000_ffff_0000, 32'h8000_0001);

    write_size(512); random_phase(400);
    write_size(7);   random_phase(300);
    write_size(37);  random_phase(400);
    write_size(2);   random_phase(100);
    write_size(503); random_phase(450);
    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/qph_pkg.sv
design/qph_ram.sv
design/qph_front.sv
design/qph_back.sv
design/quadratic_probe_hash_table.sv
bench/hash_table_checker.sv
bench/testbench.sv
